// ----- src/bmmd_pkg.sv -----
package bmmd_pkg;

    localparam int WRAM_BANK_BYTES_DEF = 4096;
    localparam int WRAM_BANKS_DEF      = 8;
    localparam int PALETTE_BYTES       = 64;
    localparam int VRAM_BYTES          = 16384;
    localparam int OAM_BYTES           = 160;
    localparam int HRAM_BYTES          = 127;

    localparam logic [6:0] IO_JOYPAD  = 7'h00;
    localparam logic [6:0] IO_LCDC    = 7'h40;
    localparam logic [6:0] IO_STAT    = 7'h41;
    localparam logic [6:0] IO_LY      = 7'h44;
    localparam logic [6:0] IO_OAM_DMA = 7'h46;
    localparam logic [6:0] IO_KEY1    = 7'h4D;
    localparam logic [6:0] IO_VBK     = 7'h4F;
    localparam logic [6:0] IO_VDMA    = 7'h55;
    localparam logic [6:0] IO_BGPI    = 7'h68;
    localparam logic [6:0] IO_BGPD    = 7'h69;
    localparam logic [6:0] IO_OBPI    = 7'h6A;
    localparam logic [6:0] IO_OBPD    = 7'h6B;
    localparam logic [6:0] IO_SVBK    = 7'h70;

    localparam logic [1:0] DMA_NONE = 2'd0;
    localparam logic [1:0] DMA_OAM  = 2'd1;
    localparam logic [1:0] DMA_VRAM = 2'd2;

    typedef enum logic [2:0] {
        RG_CART, RG_VRAM, RG_WRAM, RG_OAM, RG_HOLE, RG_IO, RG_HRAM, RG_IE
    } region_t;

    typedef struct packed {
        logic capture;
        logic exec;
    } dp_cmd_t;

endpackage

// ----- src/bmmd_ctrl.sv -----
module bmmd_ctrl
    import bmmd_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    output dp_cmd_t cmd
);

    typedef enum logic {ST_IDLE, ST_EXEC} state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign s_ready     = (state_reg == ST_IDLE) && (!out_valid_reg || m_ready);
    assign m_valid     = out_valid_reg;
    assign cmd.capture = s_valid && s_ready;
    assign cmd.exec    = (state_reg == ST_EXEC);

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.capture) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next     = ST_IDLE;
                out_valid_next = 1'b1;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- src/bmmd_dp.sv -----
module bmmd_dp
    import bmmd_pkg::*;
#(
    parameter int WRAM_BANK_BYTES = WRAM_BANK_BYTES_DEF,
    parameter int WRAM_BANKS      = WRAM_BANKS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  dp_cmd_t     cmd,
    input  logic        s_cmd,
    input  logic [15:0] s_bus_address,
    input  logic [7:0]  s_write_data,
    output logic [7:0]  m_read_data,
    output logic        m_cart_forward,
    output logic [1:0]  m_dma_request,
    output logic [7:0]  m_dma_value
);

    localparam int WRAM_BYTES = WRAM_BANKS * WRAM_BANK_BYTES;
    localparam int WA         = $clog2(WRAM_BYTES);
    localparam int OFS_W      = $clog2(WRAM_BANK_BYTES);
    localparam int BANK_W     = WA - OFS_W;
    localparam int PA         = $clog2(PALETTE_BYTES);

    logic [7:0] vram_mem [VRAM_BYTES];
    logic [7:0] wram_mem [WRAM_BYTES];
    logic [7:0] oam_mem  [OAM_BYTES];
    logic [7:0] hram_mem [HRAM_BYTES];
    logic [7:0] bgc_mem  [PALETTE_BYTES];
    logic [7:0] obc_mem  [PALETTE_BYTES];
    logic [7:0] io_mem   [128];
    logic [7:0] ie_reg;

    // I/O registers with special rules or used by the decoder live in flops;
    // the rest sit in io_mem and read their reset default until written
    logic [127:0] io_set_reg;
    logic [7:0]   joyp_reg, key1_reg, vbk_reg, bgpi_reg, obpi_reg, svbk_reg;
    logic         io_plain;

    logic [7:0] vram_q, wram_q, oam_q, hram_q, bgc_q, obc_q, io_q;
    logic       io_set_q;

    region_t     rg_in, rg_reg;
    logic        wr_reg;
    logic [7:0]  data_reg;
    logic [6:0]  io_a_reg;
    logic [13:0] vram_a_in, vram_a_reg;
    logic [WA-1:0] wram_a_in, wram_a_reg;
    logic [7:0]  oam_a_reg;
    logic [6:0]  hram_a_reg;
    logic [2:0]  bank_sel;
    logic [12:0] echo_ofs;
    logic [PA-1:0] bg_idx, ob_idx;

    always_comb begin
        if (s_bus_address < 16'h8000 ||
            (s_bus_address >= 16'hA000 && s_bus_address < 16'hC000)) begin
            rg_in = RG_CART;
        end else if (s_bus_address < 16'hA000) begin
            rg_in = RG_VRAM;
        end else if (s_bus_address < 16'hFE00) begin
            rg_in = RG_WRAM;
        end else if (s_bus_address < 16'hFEA0) begin
            rg_in = RG_OAM;
        end else if (s_bus_address < 16'hFF00) begin
            rg_in = RG_HOLE;
        end else if (s_bus_address < 16'hFF80) begin
            rg_in = RG_IO;
        end else if (s_bus_address < 16'hFFFF) begin
            rg_in = RG_HRAM;
        end else begin
            rg_in = RG_IE;
        end
    end

    always_comb begin
        bank_sel = svbk_reg[2:0];
        if (bank_sel == 3'd0) begin
            bank_sel = 3'd1;
        end
        if (32'(bank_sel) >= WRAM_BANKS) begin
            bank_sel = 3'(WRAM_BANKS - 1);
        end
        echo_ofs  = s_bus_address[12:0] - 13'h0000;
        vram_a_in = {vbk_reg[0], s_bus_address[12:0]};
        if (s_bus_address < 16'hD000) begin
            wram_a_in = WA'(s_bus_address[11:0]);
        end else if (s_bus_address < 16'hE000) begin
            wram_a_in = {BANK_W'(bank_sel), s_bus_address[OFS_W-1:0]};
        end else begin
            wram_a_in = WA'(echo_ofs);
        end
    end

    assign bg_idx = bgpi_reg[PA-1:0];
    assign ob_idx = obpi_reg[PA-1:0];

    assign io_plain = !(io_a_reg inside {IO_JOYPAD, IO_LY, IO_KEY1, IO_VBK, IO_BGPI,
                                         IO_BGPD, IO_OBPI, IO_OBPD, IO_SVBK});

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            rg_reg     <= rg_in;
            wr_reg     <= s_cmd;
            data_reg   <= s_write_data;
            io_a_reg   <= s_bus_address[6:0];
            vram_a_reg <= vram_a_in;
            wram_a_reg <= wram_a_in;
            oam_a_reg  <= s_bus_address[7:0];
            hram_a_reg <= s_bus_address[6:0];
            vram_q     <= vram_mem[vram_a_in];
            wram_q     <= wram_mem[wram_a_in];
            oam_q      <= oam_mem[8'(s_bus_address[7:0] < 8'(OAM_BYTES) ?
                                     s_bus_address[7:0] : 8'd0)];
            hram_q     <= hram_mem[7'(s_bus_address[6:0] < 7'(HRAM_BYTES) ?
                                      s_bus_address[6:0] : 7'd0)];
            bgc_q      <= bgc_mem[bg_idx];
            obc_q      <= obc_mem[ob_idx];
            io_q       <= io_mem[s_bus_address[6:0]];
            io_set_q   <= io_set_reg[s_bus_address[6:0]];
        end
    end

    logic exec_wr;
    assign exec_wr = cmd.exec && wr_reg;

    always_ff @(posedge aclk) begin
        if (exec_wr) begin
            case (rg_reg)
                RG_VRAM: vram_mem[vram_a_reg] <= data_reg;
                RG_WRAM: wram_mem[wram_a_reg] <= data_reg;
                RG_OAM:  oam_mem[oam_a_reg] <= data_reg;
                RG_HRAM: hram_mem[hram_a_reg] <= data_reg;
                RG_IO: begin
                    if (io_a_reg == IO_BGPD) begin
                        bgc_mem[bg_idx] <= data_reg;
                    end
                    if (io_a_reg == IO_OBPD) begin
                        obc_mem[ob_idx] <= data_reg;
                    end
                    if (io_plain) begin
                        io_mem[io_a_reg] <= data_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    function automatic logic [7:0] pal_step(input logic [7:0] idx);
        pal_step = idx[7] ? {2'b10, 6'(idx[5:0] + 6'd1)} : idx;
    endfunction

    function automatic logic [7:0] io_default(input logic [6:0] r);
        case (r)
            IO_OAM_DMA:       io_default = 8'hFF;
            IO_LCDC, IO_STAT: io_default = 8'h80;
            default:          io_default = 8'h00;
        endcase
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            io_set_reg <= '0;
            joyp_reg   <= 8'h0F;
            key1_reg   <= 8'h00;
            vbk_reg    <= 8'h00;
            bgpi_reg   <= 8'h00;
            obpi_reg   <= 8'h00;
            svbk_reg   <= 8'h00;
            ie_reg     <= 8'h00;
        end else if (exec_wr) begin
            if (rg_reg == RG_IE) begin
                ie_reg <= data_reg;
            end
            if (rg_reg == RG_IO) begin
                case (io_a_reg)
                    IO_JOYPAD: joyp_reg <= {data_reg[7:4], joyp_reg[3:0]};
                    IO_LY:     ;
                    IO_KEY1:   key1_reg <= {key1_reg[7] | data_reg[7], data_reg[6:0]};
                    IO_VBK:    vbk_reg  <= data_reg;
                    IO_BGPI:   bgpi_reg <= data_reg;
                    IO_BGPD:   bgpi_reg <= pal_step(bgpi_reg);
                    IO_OBPI:   obpi_reg <= data_reg;
                    IO_OBPD:   obpi_reg <= pal_step(obpi_reg);
                    IO_SVBK:   svbk_reg <= {5'd0, data_reg[2:0]};
                    default:   io_set_reg[io_a_reg] <= 1'b1;
                endcase
            end
        end
    end

    logic [7:0] io_v, rd;
    logic [1:0] dreq;

    always_comb begin
        io_v = io_set_q ? io_q : io_default(io_a_reg);
        rd   = 8'h00;
        dreq = DMA_NONE;
        if (!wr_reg) begin
            case (rg_reg)
                RG_VRAM: rd = vram_q;
                RG_WRAM: rd = wram_q;
                RG_OAM:  rd = oam_q;
                RG_HRAM: rd = hram_q;
                RG_IE:   rd = ie_reg;
                RG_IO: begin
                    case (io_a_reg)
                        IO_BGPD:   rd = bgc_q;
                        IO_OBPD:   rd = obc_q;
                        IO_JOYPAD: rd = (joyp_reg[5:4] == 2'b11) ? 8'h3F : joyp_reg;
                        IO_KEY1:   rd = key1_reg;
                        IO_VBK:    rd = vbk_reg;
                        IO_BGPI:   rd = bgpi_reg;
                        IO_OBPI:   rd = obpi_reg;
                        IO_SVBK:   rd = svbk_reg;
                        default:   rd = io_v;
                    endcase
                end
                default: rd = 8'h00;
            endcase
        end else if (rg_reg == RG_IO) begin
            if (io_a_reg == IO_OAM_DMA) begin
                dreq = DMA_OAM;
            end else if (io_a_reg == IO_VDMA) begin
                dreq = DMA_VRAM;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            m_read_data    <= rd;
            m_cart_forward <= (rg_reg == RG_CART);
            m_dma_request  <= dreq;
            m_dma_value    <= (dreq != DMA_NONE) ? data_reg : 8'h00;
        end
    end

endmodule

// ----- src/banked_memory_map_decoder.sv -----
// Banked memory map decoder.
// Input channel (s_valid/s_ready): one CPU bus beat per item: s_cmd (0 read,
// 1 write), s_bus_address, s_write_data.
// Result channel (m_valid/m_ready): one beat per item: m_read_data,
// m_cart_forward, m_dma_request, m_dma_value.
// The RAMs are read synchronously at the accepting edge; the update and the
// result register follow in the EXEC state, and m_valid then rises from the
// registered output valid flag.
// No new item is taken while the previous one is in EXEC: each item reads
// the memory ports when accepted and updates them in EXEC.
// A new item is taken while the previous result sits in the output register;
// if the receiver stalls, the result holds and one more item is accepted only
// once the output register is being drained.
// Reset (aresetn low, synchronous) clears the handshake state, the I/O
// register file to its defaults and the interrupt enable byte; the RAMs keep
// their contents and are undefined until written. No clearing pass is run.
// Cartridge ranges return cart_forward = 1 and are not stored here.
module banked_memory_map_decoder
    import bmmd_pkg::*;
#(
    parameter int WRAM_BANK_BYTES = WRAM_BANK_BYTES_DEF,
    parameter int WRAM_BANKS      = WRAM_BANKS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [15:0] s_bus_address,
    input  logic [7:0]  s_write_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_read_data,
    output logic        m_cart_forward,
    output logic [1:0]  m_dma_request,
    output logic [7:0]  m_dma_value
);

    dp_cmd_t cmd;

    bmmd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    bmmd_dp #(
        .WRAM_BANK_BYTES (WRAM_BANK_BYTES),
        .WRAM_BANKS      (WRAM_BANKS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .s_cmd          (s_cmd),
        .s_bus_address  (s_bus_address),
        .s_write_data   (s_write_data),
        .m_read_data    (m_read_data),
        .m_cart_forward (m_cart_forward),
        .m_dma_request  (m_dma_request),
        .m_dma_value    (m_dma_value)
    );

endmodule

// ----- src/bmmd_checker.sv -----
module bmmd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_read_data,
    input logic       m_cart_forward,
    input logic [1:0] m_dma_request,
    input logic [7:0] m_dma_value
);

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_data))
        else $error("result dropped while stalled");

    a_one_result_per_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !m_valid ##1 m_valid)
        else $error("result not two cycles after input beat");

    a_cart_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_cart_forward |-> m_read_data == 8'h00 && m_dma_request == 2'd0)
        else $error("cartridge beat carries data");

    a_dma_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_dma_request != 2'd3 &&
                    (m_dma_request != 2'd0 || m_dma_value == 8'h00))
        else $error("bad dma fields");

    a_no_ready_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken during execute");

endmodule

bind banked_memory_map_decoder bmmd_checker u_bmmd_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_read_data    (m_read_data),
    .m_cart_forward (m_cart_forward),
    .m_dma_request  (m_dma_request),
    .m_dma_value    (m_dma_value)
);

// ----- tb/tb_banked_memory_map_decoder.sv -----
module tb_banked_memory_map_decoder;
    import bmmd_pkg::*;

    localparam int N_RANDOM = 1350;
    localparam int WDOG_LIMIT = 5000;
    localparam int NBANKS = WRAM_BANKS_DEF;
    localparam int BANK_BYTES = WRAM_BANK_BYTES_DEF;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_cmd;
    logic [15:0] s_bus_address;
    logic [7:0]  s_write_data;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_read_data;
    logic        m_cart_forward;
    logic [1:0]  m_dma_request;
    logic [7:0]  m_dma_value;

    banked_memory_map_decoder dut (.*);

    typedef struct packed {
        logic [7:0] rdata;
        logic       cart;
        logic [1:0] dreq;
        logic [7:0] dval;
    } bus_result_t;

    typedef struct {
        logic        wr;
        logic [15:0] addr;
        logic [7:0]  data;
        logic        fixed;
        bus_result_t res;
    } access_row_t;

    // predictor state
    logic [7:0] vram_q [0:VRAM_BYTES-1];
    logic [7:0] wram_q [0:NBANKS*BANK_BYTES-1];
    logic [7:0] oam_q  [0:OAM_BYTES-1];
    logic [7:0] hram_q [0:HRAM_BYTES-1];
    logic [7:0] bgpal_q [0:PALETTE_BYTES-1];
    logic [7:0] objpal_q [0:PALETTE_BYTES-1];
    logic [7:0] io_q   [0:127];
    logic [7:0] ie_q;
    // written-map so random reads only touch defined entries
    bit vram_ok [0:VRAM_BYTES-1];
    bit wram_ok [0:NBANKS*BANK_BYTES-1];
    bit oam_ok  [0:OAM_BYTES-1];
    bit hram_ok [0:HRAM_BYTES-1];
    bit bgpal_ok [0:PALETTE_BYTES-1];
    bit objpal_ok [0:PALETTE_BYTES-1];

    bus_result_t expected_q[$];
    int  errors;
    int  idle_cycles;
    bit  done;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic int vram_idx(logic [15:0] a);
        return int'(io_q[IO_VBK][0]) * 8192 + int'(a[12:0]);
    endfunction

    function automatic int wram_idx(logic [15:0] a);
        int bank;
        if (a < 16'hD000) return int'(a - 16'hC000);
        if (a >= 16'hE000) return int'(a - 16'hE000);
        bank = int'(io_q[IO_SVBK][2:0]);
        if (bank == 0) bank = 1;
        if (bank >= NBANKS) bank = NBANKS - 1;
        return bank * BANK_BYTES + int'(a[11:0]);
    endfunction

    function automatic void memmap_reset();
        foreach (io_q[i]) io_q[i] = 8'h00;
        io_q[IO_OAM_DMA] = 8'hFF;
        io_q[IO_JOYPAD]  = 8'h0F;
        io_q[IO_LCDC]    = 8'h80;
        io_q[IO_STAT]    = 8'h80;
        ie_q = 8'h00;
    endfunction

    function automatic bit readable(logic [15:0] a);
        logic [6:0] r;
        if (a < 16'h8000 || (a >= 16'hA000 && a < 16'hC000)) return 1;
        if (a < 16'hA000) return vram_ok[vram_idx(a)];
        if (a < 16'hFE00) return wram_ok[wram_idx(a)];
        if (a < 16'hFEA0) return oam_ok[a - 16'hFE00];
        if (a < 16'hFF00) return 1;
        if (a < 16'hFF80) begin
            r = a[6:0];
            if (r == IO_BGPD) return bgpal_ok[io_q[IO_BGPI][5:0]];
            if (r == IO_OBPD) return objpal_ok[io_q[IO_OBPI][5:0]];
            return 1;
        end
        if (a < 16'hFFFF) return hram_ok[a - 16'hFF80];
        return 1;
    endfunction

    function automatic bus_result_t predict_access(logic wr, logic [15:0] a, logic [7:0] d);
        bus_result_t res;
        logic [6:0] r;
        logic [7:0] pidx;
        int k;
        res = '{8'h00, 1'b0, DMA_NONE, 8'h00};
        if (a < 16'h8000 || (a >= 16'hA000 && a < 16'hC000)) begin
            res.cart = 1'b1;
        end else if (a < 16'hA000) begin
            k = vram_idx(a);
            if (wr) begin vram_q[k] = d; vram_ok[k] = 1; end else res.rdata = vram_q[k];
        end else if (a < 16'hFE00) begin
            k = wram_idx(a);
            if (wr) begin wram_q[k] = d; wram_ok[k] = 1; end else res.rdata = wram_q[k];
        end else if (a < 16'hFEA0) begin
            k = int'(a - 16'hFE00);
            if (wr) begin oam_q[k] = d; oam_ok[k] = 1; end else res.rdata = oam_q[k];
        end else if (a < 16'hFF00) begin
        end else if (a < 16'hFF80) begin
            r = a[6:0];
            if (!wr) begin
                if (r == IO_BGPD) res.rdata = bgpal_q[io_q[IO_BGPI][5:0]];
                else if (r == IO_OBPD) res.rdata = objpal_q[io_q[IO_OBPI][5:0]];
                else if (r == IO_JOYPAD && io_q[r][5:4] == 2'b11) res.rdata = 8'h3F;
                else res.rdata = io_q[r];
            end else begin
                case (r)
                    IO_JOYPAD: io_q[r] = {d[7:4], io_q[r][3:0]};
                    IO_LY: ;
                    IO_KEY1: io_q[r] = (io_q[r] & 8'h80) | d;
                    IO_BGPD: begin
                        pidx = io_q[IO_BGPI];
                        bgpal_q[pidx[5:0]] = d;
                        bgpal_ok[pidx[5:0]] = 1;
                        if (pidx[7]) io_q[IO_BGPI] = {2'b10, pidx[5:0] + 6'd1};
                    end
                    IO_OBPD: begin
                        pidx = io_q[IO_OBPI];
                        objpal_q[pidx[5:0]] = d;
                        objpal_ok[pidx[5:0]] = 1;
                        if (pidx[7]) io_q[IO_OBPI] = {2'b10, pidx[5:0] + 6'd1};
                    end
                    IO_SVBK: io_q[r] = {5'd0, d[2:0]};
                    IO_OAM_DMA: begin io_q[r] = d; res.dreq = DMA_OAM; res.dval = d; end
                    IO_VDMA: begin io_q[r] = d; res.dreq = DMA_VRAM; res.dval = d; end
                    default: io_q[r] = d;
                endcase
            end
        end else if (a < 16'hFFFF) begin
            k = int'(a - 16'hFF80);
            if (wr) begin hram_q[k] = d; hram_ok[k] = 1; end else res.rdata = hram_q[k];
        end else begin
            if (wr) ie_q = d; else res.rdata = ie_q;
        end
        return res;
    endfunction

    task automatic send_access(logic wr, logic [15:0] a, logic [7:0] d,
                               bit fixed, bus_result_t fixed_res);
        bus_result_t res;
        int gap;
        if ($urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 6);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_cmd         <= wr;
        s_bus_address <= a;
        s_write_data  <= d;
        do @(posedge aclk); while (!s_ready);
        res = predict_access(wr, a, d);
        if (fixed && res != fixed_res) begin
            $error("directed row %h: predictor disagrees with typed result", a);
            errors++;
        end
        expected_q.push_back(fixed ? fixed_res : res);
    endtask

    // result checker
    always @(posedge aclk) begin
        bus_result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                $error("result beat with no expectation pending");
                errors++;
            end else begin
                e = expected_q.pop_front();
                if (m_read_data !== e.rdata) begin
                    $error("read_data exp %h got %h", e.rdata, m_read_data); errors++;
                end
                if (m_cart_forward !== e.cart) begin
                    $error("cart_forward exp %h got %h", e.cart, m_cart_forward); errors++;
                end
                if (m_dma_request !== e.dreq) begin
                    $error("dma_request exp %h got %h", e.dreq, m_dma_request); errors++;
                end
                if (m_dma_value !== e.dval) begin
                    $error("dma_value exp %h got %h", e.dval, m_dma_value); errors++;
                end
            end
        end
    end

    // receiver stall pattern: each cycle picks free flow or a random stall
    always @(posedge aclk) begin
        int phase;
        phase = ($urandom_range(0, 63) < 40) ? 0 : 1;
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= (phase == 0) ? 1'b1 : ($urandom_range(0, 2) == 0);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || done)
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [15:0] pick_address();
        logic [15:0] a;
        int sel;
        sel = $urandom_range(0, 15);
        case (sel)
            0:  a = 16'($urandom_range(0, 16'hFFFF));
            1:  a = 16'($urandom_range(16'h8000, 16'h9FFF));
            2, 3: a = 16'($urandom_range(16'hC000, 16'hDFFF));
            4:  a = 16'($urandom_range(16'hE000, 16'hFDFF));
            5:  a = 16'($urandom_range(16'hFE00, 16'hFEFF));
            6, 7, 8: a = 16'($urandom_range(16'hFF00, 16'hFF7F));
            9:  a = 16'hFF00 | {9'd0, IO_BGPD};
            10: a = 16'hFF00 | {9'd0, IO_OBPD};
            11: a = 16'hFF00 | {9'd0, IO_SVBK};
            12: a = 16'hFF00 | {9'd0, IO_VBK};
            13: a = 16'($urandom_range(16'hFF80, 16'hFFFF));
            default: a = ($urandom_range(0, 1) ? 16'hFF00 | {9'd0, IO_BGPI}
                                               : 16'hFF00 | {9'd0, IO_OBPI});
        endcase
        return a;
    endfunction

    access_row_t dir_rows[$];
    bus_result_t none_r;

    initial begin
        logic [15:0] a;
        logic wr;
        int n;
        bus_result_t cart_r;
        none_r = '{8'h00, 1'b0, DMA_NONE, 8'h00};
        cart_r = '{8'h00, 1'b1, DMA_NONE, 8'h00};
        errors = 0;
        done = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_cmd = 1'b0;
        s_bus_address = 16'h0;
        s_write_data = 8'h0;
        memmap_reset();
        foreach (vram_ok[i]) vram_ok[i] = 0;
        foreach (wram_ok[i]) wram_ok[i] = 0;
        foreach (oam_ok[i]) oam_ok[i] = 0;
        foreach (hram_ok[i]) hram_ok[i] = 0;
        foreach (bgpal_ok[i]) bgpal_ok[i] = 0;
        foreach (objpal_ok[i]) objpal_ok[i] = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        dir_rows = '{
            '{0, 16'hFF00, 8'h00, 1, '{8'h0F, 0, DMA_NONE, 8'h00}},
            '{0, 16'hFF40, 8'h00, 1, '{8'h80, 0, DMA_NONE, 8'h00}},
            '{0, 16'hFF46, 8'h00, 1, '{8'hFF, 0, DMA_NONE, 8'h00}},
            '{0, 16'hFFFF, 8'h00, 1, '{8'h00, 0, DMA_NONE, 8'h00}},
            '{0, 16'h0000, 8'h00, 1, cart_r},
            '{1, 16'h7FFF, 8'hFF, 1, cart_r},
            '{0, 16'hA000, 8'h00, 1, cart_r},
            '{1, 16'hBFFF, 8'hA5, 1, cart_r},
            '{1, 16'hFEA0, 8'h55, 1, none_r},
            '{0, 16'hFEFF, 8'h00, 1, none_r},
            '{1, 16'hFF00, 8'hF0, 1, none_r},
            '{0, 16'hFF00, 8'h00, 1, '{8'h3F, 0, DMA_NONE, 8'h00}},
            '{1, 16'hFF46, 8'hC3, 1, '{8'h00, 0, DMA_OAM, 8'hC3}},
            '{1, 16'hFF55, 8'h81, 1, '{8'h00, 0, DMA_VRAM, 8'h81}},
            '{1, 16'hFF44, 8'h12, 0, none_r},
            '{0, 16'hFF44, 8'h00, 0, none_r},
            '{1, 16'hFF4D, 8'h80, 0, none_r},
            '{1, 16'hFF4D, 8'h01, 0, none_r},
            '{0, 16'hFF4D, 8'h00, 0, none_r},
            '{1, 16'hFF68, 8'hBF, 0, none_r},
            '{1, 16'hFF69, 8'h11, 0, none_r},
            '{1, 16'hFF69, 8'h22, 0, none_r},
            '{0, 16'hFF68, 8'h00, 0, none_r},
            '{1, 16'hFF70, 8'hFF, 0, none_r},
            '{1, 16'hDFFF, 8'h77, 0, none_r},
            '{1, 16'hFFFF, 8'h1F, 0, none_r},
            '{0, 16'hFFFF, 8'h00, 0, none_r}
        };
        foreach (dir_rows[i])
            send_access(dir_rows[i].wr, dir_rows[i].addr, dir_rows[i].data,
                        dir_rows[i].fixed, dir_rows[i].res);

        n = 0;
        while (n < N_RANDOM) begin
            wr = 1'($urandom_range(0, 1));
            a = pick_address();
            if (!wr && !readable(a)) wr = 1'b1;
            send_access(wr, a, 8'($urandom_range(0, 255)), 0, none_r);
            n++;
        end
        s_valid <= 1'b0;

        while (expected_q.size() != 0) @(posedge aclk);
        done = 1;
        repeat (10) @(posedge aclk);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
